// ===== src/tclp_pkg.sv =====
// shared types and constants for the text command line parser
package tclp_pkg;

    // parser phases
    localparam logic [3:0] PH_DOLLAR   = 4'd0;
    localparam logic [3:0] PH_LETTER   = 4'd1;
    localparam logic [3:0] PH_COMMA    = 4'd2;
    localparam logic [3:0] PH_F1_START = 4'd3;
    localparam logic [3:0] PH_F1_MORE  = 4'd4;
    localparam logic [3:0] PH_F2_START = 4'd5;
    localparam logic [3:0] PH_F2_MORE  = 4'd6;
    localparam logic [3:0] PH_HEX_HIGH = 4'd7;
    localparam logic [3:0] PH_HEX_LOW  = 4'd8;
    localparam logic [3:0] PH_HEX_SEP  = 4'd9;
    localparam logic [3:0] PH_DONE     = 4'd10;

    // command letters
    localparam logic [1:0] CMD_NONE = 2'd0;
    localparam logic [1:0] CMD_SIG  = 2'd1;
    localparam logic [1:0] CMD_AREA = 2'd2;
    localparam logic [1:0] CMD_INCL = 2'd3;

    // write kinds
    localparam logic [1:0] WK_NONE = 2'd0;
    localparam logic [1:0] WK_SIG  = 2'd1;
    localparam logic [1:0] WK_INCL = 2'd2;
    localparam logic [1:0] WK_AREA = 2'd3;

    // status codes
    localparam logic [3:0] ST_OK           = 4'd0;
    localparam logic [3:0] ST_NO_DOLLAR    = 4'd1;
    localparam logic [3:0] ST_NO_COMMA     = 4'd2;
    localparam logic [3:0] ST_BAD_START    = 4'd3;
    localparam logic [3:0] ST_BAD_CHAR     = 4'd4;
    localparam logic [3:0] ST_BAD_START2   = 4'd5;
    localparam logic [3:0] ST_BAD_CHAR2    = 4'd6;
    localparam logic [3:0] ST_OUT_OF_RANGE = 4'd7;
    localparam logic [3:0] ST_UNKNOWN      = 4'd8;

    // configuration register indexes
    localparam logic [1:0] REG_MAX_INDEX  = 2'd0;
    localparam logic [1:0] REG_MAX_SIGNAL = 2'd1;

    localparam logic [7:0] MAX_INDEX_RST  = 8'd99;
    localparam logic [7:0] MAX_SIGNAL_RST = 8'd3;

    // characters
    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_0      = 8'h30;
    localparam logic [7:0] CH_9      = 8'h39;
    localparam logic [7:0] CH_A      = 8'h41;
    localparam logic [7:0] CH_F      = 8'h46;
    localparam logic [7:0] CH_K      = 8'h4B;
    localparam logic [7:0] CH_S      = 8'h53;
    localparam logic [7:0] CH_I      = 8'h49;

    typedef struct packed {
        logic [3:0] phase;
        logic [1:0] cmd;
        logic [3:0] dcnt;
        logic [7:0] acc;
        logic [7:0] first;
        logic [4:0] group;
        logic [3:0] high;
    } t_state;

    typedef struct packed {
        logic       valid;
        logic [1:0] kind;
        logic [7:0] target;
        logic [7:0] value;
        logic       status_valid;
        logic [3:0] status;
    } t_result;

    localparam t_state STATE_RST = '{
        phase: PH_DOLLAR, cmd: CMD_NONE, dcnt: 4'd0, acc: 8'd0,
        first: 8'd0, group: 5'd0, high: 4'd0
    };

endpackage

// ===== src/text_command_line_parser.sv =====
// top level of the text command line parser
//
// Characters come in on the input channel (i_valid / o_ready, i_ch), one
// request per character; a zero byte ends the line. Each character passes
// an input register, one parser step, and a result register that drives the
// output channel (o_valid / i_ready). A character that completes a write or
// a command status produces one result request; others produce none.
// A result passes the input register and then the result register before it is offered.
// Throughput: one character per cycle while the receiver does not stall, set by the
// single-step parser between the two registers.
// When the receiver stalls, the result register holds its request and the
// input register absorbs one more character, after which o_ready drops.
// The configuration channel (i_cfg_valid / o_cfg_ready) is always ready and
// writes max_index (index 0) or max_signal (index 1); write it only while
// the parser is idle.
// Synchronous active-low reset empties both registers, returns the parser
// to expecting a dollar and restores max_index 99 and max_signal 3.
module text_command_line_parser #(
    parameter int AREA_BYTES = 18,
    parameter int MAX_DIGITS = 10
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_ch,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [1:0] o_write_kind,
    output logic [7:0] o_target_index,
    output logic [7:0] o_write_value,
    output logic       o_status_valid,
    output logic [3:0] o_status,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [1:0] i_cfg_index,
    input  logic [7:0] i_cfg_data
);

    logic              r_in_valid;
    logic [7:0]        r_ch;
    tclp_pkg::t_state  r_state;
    tclp_pkg::t_state  n_state;
    tclp_pkg::t_result n_result;
    tclp_pkg::t_result r_out;
    logic [7:0]        r_max_index;
    logic [7:0]        r_max_signal;
    logic              adv;

    // parser step
    tclp_step #(
        .AREA_BYTES (AREA_BYTES),
        .MAX_DIGITS (MAX_DIGITS)
    ) u_step (
        .i_state      (r_state),
        .i_ch         (r_ch),
        .i_max_index  (r_max_index),
        .i_max_signal (r_max_signal),
        .o_state      (n_state),
        .o_result     (n_result)
    );

    // handshake
    assign adv         = r_in_valid && (!r_out.valid || i_ready);
    assign o_ready     = !r_in_valid || adv;
    assign o_cfg_ready = 1'b1;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
        if (i_valid && o_ready) begin
            r_ch <= i_ch;
        end
    end

    // parser state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tclp_pkg::STATE_RST;
        end else if (adv) begin
            r_state <= n_state;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out <= '0;
        end else if (adv) begin
            r_out <= n_result;
        end else if (i_ready) begin
            r_out.valid <= 1'b0;
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_index  <= tclp_pkg::MAX_INDEX_RST;
            r_max_signal <= tclp_pkg::MAX_SIGNAL_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                tclp_pkg::REG_MAX_INDEX:  r_max_index  <= i_cfg_data;
                tclp_pkg::REG_MAX_SIGNAL: r_max_signal <= i_cfg_data;
                default: begin
                    r_max_index <= r_max_index;
                end
            endcase
        end
    end

    assign o_valid        = r_out.valid;
    assign o_write_kind   = r_out.kind;
    assign o_target_index = r_out.target;
    assign o_write_value  = r_out.value;
    assign o_status_valid = r_out.status_valid;
    assign o_status       = r_out.status;

endmodule

// ===== src/tclp_step.sv =====
// one parser step: next state and result for one character
module tclp_step #(
    parameter int AREA_BYTES = 18,
    parameter int MAX_DIGITS = 10
) (
    input  tclp_pkg::t_state  i_state,
    input  logic [7:0]        i_ch,
    input  logic [7:0]        i_max_index,
    input  logic [7:0]        i_max_signal,
    output tclp_pkg::t_state  o_state,
    output tclp_pkg::t_result o_result
);

    localparam logic [3:0] MaxDig   = 4'(MAX_DIGITS);
    localparam logic [5:0] AreaLast = 6'(AREA_BYTES);

    // character classes
    logic       is_dec;
    logic       is_hex;
    logic       is_end;
    logic [3:0] hex_val;
    logic [3:0] dec_val;

    assign is_dec  = (i_ch >= tclp_pkg::CH_0) && (i_ch <= tclp_pkg::CH_9);
    assign is_hex  = is_dec || ((i_ch >= tclp_pkg::CH_A) && (i_ch <= tclp_pkg::CH_F));
    assign is_end  = (i_ch == tclp_pkg::CH_NUL) || (i_ch == tclp_pkg::CH_COMMA);
    assign dec_val = 4'(i_ch - tclp_pkg::CH_0);
    assign hex_val = is_dec ? dec_val : 4'(i_ch - tclp_pkg::CH_A + 8'd10);

    // decimal accumulate with saturation at 255
    logic [7:0]  acc_base;
    logic [3:0]  cnt_base;
    logic [11:0] prod;
    logic [7:0]  acc_new;
    logic [3:0]  cnt_new;
    logic        cnt_full;

    assign acc_base = (i_state.phase == tclp_pkg::PH_F2_START) ? 8'd0 : i_state.acc;
    assign cnt_base = (i_state.phase == tclp_pkg::PH_F2_START) ? 4'd0 : i_state.dcnt;
    assign prod     = {4'd0, acc_base} * 12'd10 + {8'd0, dec_val};
    assign acc_new  = (prod > 12'd255) ? 8'd255 : prod[7:0];
    assign cnt_new  = cnt_base + 4'd1;
    assign cnt_full = cnt_new >= MaxDig;

    // second field complete: range check and write
    logic [7:0]         fin_val;
    tclp_pkg::t_result  fin_res;

    assign fin_val = (i_state.phase == tclp_pkg::PH_F2_MORE && is_end) ? i_state.acc : acc_new;

    always_comb begin
        fin_res = '0;
        fin_res.valid        = 1'b1;
        fin_res.status_valid = 1'b1;
        if (i_state.first > i_max_index) begin
            fin_res.status = tclp_pkg::ST_OUT_OF_RANGE;
        end else if (i_state.cmd == tclp_pkg::CMD_SIG) begin
            if (fin_val > i_max_signal) begin
                fin_res.status = tclp_pkg::ST_OUT_OF_RANGE;
            end else begin
                fin_res.kind   = tclp_pkg::WK_SIG;
                fin_res.target = i_state.first;
                fin_res.value  = fin_val;
            end
        end else begin
            fin_res.kind   = tclp_pkg::WK_INCL;
            fin_res.target = i_state.first;
            fin_res.value  = {7'd0, fin_val != 8'd0};
        end
    end

    // phase step
    tclp_pkg::t_state  n_st;
    tclp_pkg::t_result res;
    logic [3:0]        fail_code;
    logic              fail;
    logic [7:0]        fail_tgt;

    always_comb begin
        n_st      = i_state;
        res       = '0;
        fail      = 1'b0;
        fail_code = tclp_pkg::ST_OK;
        fail_tgt  = 8'd0;
        case (i_state.phase)
            tclp_pkg::PH_DOLLAR: begin
                if (i_ch != tclp_pkg::CH_DOLLAR) begin
                    fail      = 1'b1;
                    fail_code = tclp_pkg::ST_NO_DOLLAR;
                end else begin
                    n_st.phase = tclp_pkg::PH_LETTER;
                end
            end
            tclp_pkg::PH_LETTER: begin
                n_st.phase = tclp_pkg::PH_COMMA;
                if (i_ch == tclp_pkg::CH_K) begin
                    res.valid        = 1'b1;
                    res.status_valid = 1'b1;
                    n_st.phase       = tclp_pkg::PH_DONE;
                end else if (i_ch == tclp_pkg::CH_S) begin
                    n_st.cmd = tclp_pkg::CMD_SIG;
                end else if (i_ch == tclp_pkg::CH_A) begin
                    n_st.cmd = tclp_pkg::CMD_AREA;
                end else if (i_ch == tclp_pkg::CH_I) begin
                    n_st.cmd = tclp_pkg::CMD_INCL;
                end else begin
                    fail      = 1'b1;
                    fail_code = tclp_pkg::ST_UNKNOWN;
                end
            end
            tclp_pkg::PH_COMMA: begin
                if (i_ch != tclp_pkg::CH_COMMA) begin
                    fail      = 1'b1;
                    fail_code = tclp_pkg::ST_NO_COMMA;
                end else if (i_state.cmd == tclp_pkg::CMD_AREA) begin
                    n_st.phase = tclp_pkg::PH_HEX_HIGH;
                end else begin
                    n_st.phase = tclp_pkg::PH_F1_START;
                end
            end
            tclp_pkg::PH_F1_START, tclp_pkg::PH_F1_MORE: begin
                if (i_state.phase == tclp_pkg::PH_F1_MORE && is_end) begin
                    n_st.first = i_state.acc;
                    n_st.phase = tclp_pkg::PH_F2_START;
                    if (i_ch == tclp_pkg::CH_NUL) begin
                        fail      = 1'b1;
                        fail_code = tclp_pkg::ST_BAD_START2;
                    end
                end else if (!is_dec) begin
                    fail      = 1'b1;
                    fail_code = (i_state.phase == tclp_pkg::PH_F1_START) ?
                                tclp_pkg::ST_BAD_START : tclp_pkg::ST_BAD_CHAR;
                end else if (cnt_full) begin
                    n_st.first = acc_new;
                    n_st.acc   = 8'd0;
                    n_st.dcnt  = 4'd0;
                    n_st.phase = tclp_pkg::PH_F2_START;
                end else begin
                    n_st.acc   = acc_new;
                    n_st.dcnt  = cnt_new;
                    n_st.phase = tclp_pkg::PH_F1_MORE;
                end
            end
            tclp_pkg::PH_F2_START, tclp_pkg::PH_F2_MORE: begin
                if (i_state.phase == tclp_pkg::PH_F2_MORE && is_end) begin
                    res        = fin_res;
                    n_st.phase = tclp_pkg::PH_DONE;
                end else if (!is_dec) begin
                    fail      = 1'b1;
                    fail_code = (i_state.phase == tclp_pkg::PH_F2_START) ?
                                tclp_pkg::ST_BAD_START2 : tclp_pkg::ST_BAD_CHAR2;
                end else if (cnt_full) begin
                    res        = fin_res;
                    n_st.phase = tclp_pkg::PH_DONE;
                end else begin
                    n_st.acc   = acc_new;
                    n_st.dcnt  = cnt_new;
                    n_st.phase = tclp_pkg::PH_F2_MORE;
                end
            end
            tclp_pkg::PH_HEX_HIGH: begin
                if (!is_hex) begin
                    fail      = 1'b1;
                    fail_code = tclp_pkg::ST_BAD_START;
                    fail_tgt  = {3'd0, i_state.group};
                end else begin
                    n_st.high  = hex_val;
                    n_st.phase = tclp_pkg::PH_HEX_LOW;
                end
            end
            tclp_pkg::PH_HEX_LOW: begin
                if (!is_hex) begin
                    fail      = 1'b1;
                    fail_code = tclp_pkg::ST_BAD_CHAR;
                    fail_tgt  = {3'd0, i_state.group};
                end else begin
                    res.valid  = 1'b1;
                    res.kind   = tclp_pkg::WK_AREA;
                    res.target = {3'd0, i_state.group};
                    res.value  = {i_state.high, hex_val};
                    if ({1'b0, i_state.group} + 6'd1 >= AreaLast) begin
                        res.status_valid = 1'b1;
                        n_st.phase       = tclp_pkg::PH_DONE;
                    end else begin
                        n_st.group = i_state.group + 5'd1;
                        n_st.phase = tclp_pkg::PH_HEX_SEP;
                    end
                end
            end
            tclp_pkg::PH_HEX_SEP: begin
                if (i_ch == tclp_pkg::CH_NUL) begin
                    fail      = 1'b1;
                    fail_code = tclp_pkg::ST_BAD_START;
                    fail_tgt  = {3'd0, i_state.group};
                end else begin
                    n_st.phase = tclp_pkg::PH_HEX_HIGH;
                end
            end
            default: begin
                n_st = i_state;
            end
        endcase

        // error status ends the command
        if (fail) begin
            res              = '0;
            res.valid        = 1'b1;
            res.status_valid = 1'b1;
            res.status       = fail_code;
            res.target       = fail_tgt;
            n_st.phase       = tclp_pkg::PH_DONE;
        end

        // end of line returns the parser to its reset state
        if (i_ch == tclp_pkg::CH_NUL) begin
            n_st = tclp_pkg::STATE_RST;
        end
    end

    assign o_state  = n_st;
    assign o_result = res;

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 1ps
// self-checking testbench for the text command line parser
module testbench;

    localparam int HALF_PERIOD  = 5;
    localparam int AREA_LEN     = 18;
    localparam int FIELD_DIGITS = 10;
    localparam int DRAIN_CYCLES = 4;
    localparam int HOLD_CYCLES  = 300;
    localparam int END_WAIT     = 5000;
    localparam int TIMEOUT_NS   = 5000000;

    // one result request as the parser should present it
    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] target;
        logic [7:0] value;
        logic       sv;
        logic [3:0] st;
    } t_write;

    logic       i_clk       = 1'b0;
    logic       i_rst_n     = 1'b0;
    logic       i_valid     = 1'b0;
    logic [7:0] i_ch        = 8'd0;
    logic       i_ready     = 1'b0;
    logic       i_cfg_valid = 1'b0;
    logic [1:0] i_cfg_index = tclp_pkg::REG_MAX_INDEX;
    logic [7:0] i_cfg_data  = 8'd0;
    logic       o_ready;
    logic       o_valid;
    logic [1:0] o_write_kind;
    logic [7:0] o_target_index;
    logic [7:0] o_write_value;
    logic       o_status_valid;
    logic [3:0] o_status;
    logic       o_cfg_ready;

    text_command_line_parser #(
        .AREA_BYTES(AREA_LEN),
        .MAX_DIGITS(FIELD_DIGITS)
    ) dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_ready(o_ready),
        .i_ch(i_ch),
        .o_valid(o_valid),
        .i_ready(i_ready),
        .o_write_kind(o_write_kind),
        .o_target_index(o_target_index),
        .o_write_value(o_write_value),
        .o_status_valid(o_status_valid),
        .o_status(o_status),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data(i_cfg_data)
    );

    // clock
    always #HALF_PERIOD i_clk = ~i_clk;

    // parser state and limits as predicted
    logic [7:0] lim_index   = tclp_pkg::MAX_INDEX_RST;
    logic [7:0] lim_signal  = tclp_pkg::MAX_SIGNAL_RST;
    logic [3:0] parse_phase = tclp_pkg::PH_DOLLAR;
    logic [1:0] cmd_letter  = tclp_pkg::CMD_NONE;
    logic [3:0] digit_cnt   = 4'd0;
    logic [7:0] acc_value   = 8'd0;
    logic [7:0] first_value = 8'd0;
    logic [4:0] area_group  = 5'd0;
    logic [3:0] high_nibble = 4'd0;

    t_write     expected_writes[$];
    logic [7:0] line_buf[$];

    // traffic shaping and bookkeeping
    bit tx_idling    = 1'b0;
    bit rx_idling    = 1'b0;
    bit hold_request = 1'b0;
    int error_count    = 0;
    int chars_sent     = 0;
    int results_seen   = 0;
    int area_seen      = 0;
    int status_seen    = 0;
    int settings_count = 0;

    function automatic bit is_dec(logic [7:0] c);
        return c >= tclp_pkg::CH_0 && c <= tclp_pkg::CH_9;
    endfunction

    function automatic bit is_hex(logic [7:0] c);
        return is_dec(c) || (c >= tclp_pkg::CH_A && c <= tclp_pkg::CH_F);
    endfunction

    function automatic logic [3:0] nibble_of(logic [7:0] c);
        logic [7:0] v;
        v = is_dec(c) ? c - tclp_pkg::CH_0 : c - tclp_pkg::CH_A + 8'd10;
        return v[3:0];
    endfunction

    function automatic void clear_parser_state();
        parse_phase = tclp_pkg::PH_DOLLAR;
        cmd_letter  = tclp_pkg::CMD_NONE;
        digit_cnt   = 4'd0;
        acc_value   = 8'd0;
        first_value = 8'd0;
        area_group  = 5'd0;
        high_nibble = 4'd0;
    endfunction

    // decimal digit with saturation at 255
    function automatic void add_digit(logic [7:0] c);
        int v;
        v = int'(acc_value) * 10 + int'(c - tclp_pkg::CH_0);
        acc_value = (v > 255) ? 8'd255 : 8'(v);
        digit_cnt = digit_cnt + 4'd1;
    endfunction

    function automatic void expect_write(logic [1:0] kind, logic [7:0] target,
                                         logic [7:0] value, logic sv, logic [3:0] st);
        t_write w;
        w.kind   = kind;
        w.target = target;
        w.value  = value;
        w.sv     = sv;
        w.st     = st;
        expected_writes.push_back(w);
    endfunction

    function automatic void expect_failure(logic [7:0] target, logic [3:0] st);
        expect_write(tclp_pkg::WK_NONE, target, 8'd0, 1'b1, st);
        parse_phase = tclp_pkg::PH_DONE;
    endfunction

    // end of a signal or include command: range checks, then the write
    function automatic void complete_field_command();
        parse_phase = tclp_pkg::PH_DONE;
        if (first_value > lim_index) begin
            expect_failure(8'd0, tclp_pkg::ST_OUT_OF_RANGE);
        end else if (cmd_letter == tclp_pkg::CMD_SIG) begin
            if (acc_value > lim_signal)
                expect_failure(8'd0, tclp_pkg::ST_OUT_OF_RANGE);
            else
                expect_write(tclp_pkg::WK_SIG, first_value, acc_value, 1'b1,
                             tclp_pkg::ST_OK);
        end else begin
            expect_write(tclp_pkg::WK_INCL, first_value, {7'd0, acc_value != 8'd0}, 1'b1,
                         tclp_pkg::ST_OK);
        end
    endfunction

    // one parser step per accepted character
    function automatic void parse_char(logic [7:0] c);
        logic [7:0] area_byte;
        case (parse_phase)
            tclp_pkg::PH_DOLLAR: begin
                if (c != tclp_pkg::CH_DOLLAR)
                    expect_failure(8'd0, tclp_pkg::ST_NO_DOLLAR);
                else
                    parse_phase = tclp_pkg::PH_LETTER;
            end
            tclp_pkg::PH_LETTER: begin
                if (c == tclp_pkg::CH_K) begin
                    expect_write(tclp_pkg::WK_NONE, 8'd0, 8'd0, 1'b1, tclp_pkg::ST_OK);
                    parse_phase = tclp_pkg::PH_DONE;
                end else if (c == tclp_pkg::CH_S || c == tclp_pkg::CH_A ||
                             c == tclp_pkg::CH_I) begin
                    cmd_letter  = (c == tclp_pkg::CH_S) ? tclp_pkg::CMD_SIG :
                                  (c == tclp_pkg::CH_A) ? tclp_pkg::CMD_AREA :
                                                          tclp_pkg::CMD_INCL;
                    parse_phase = tclp_pkg::PH_COMMA;
                end else begin
                    expect_failure(8'd0, tclp_pkg::ST_UNKNOWN);
                end
            end
            tclp_pkg::PH_COMMA: begin
                if (c != tclp_pkg::CH_COMMA)
                    expect_failure(8'd0, tclp_pkg::ST_NO_COMMA);
                else
                    parse_phase = (cmd_letter == tclp_pkg::CMD_AREA) ?
                                  tclp_pkg::PH_HEX_HIGH : tclp_pkg::PH_F1_START;
            end
            tclp_pkg::PH_F1_START, tclp_pkg::PH_F1_MORE: begin
                if (parse_phase == tclp_pkg::PH_F1_MORE &&
                    (c == tclp_pkg::CH_NUL || c == tclp_pkg::CH_COMMA)) begin
                    // first field ends; end of line leaves nothing for the second
                    first_value = acc_value;
                    parse_phase = tclp_pkg::PH_F2_START;
                    if (c == tclp_pkg::CH_NUL)
                        expect_failure(8'd0, tclp_pkg::ST_BAD_START2);
                end else if (!is_dec(c)) begin
                    expect_failure(8'd0, (parse_phase == tclp_pkg::PH_F1_START) ?
                                         tclp_pkg::ST_BAD_START : tclp_pkg::ST_BAD_CHAR);
                end else begin
                    add_digit(c);
                    if (digit_cnt >= FIELD_DIGITS) begin
                        first_value = acc_value;
                        acc_value   = 8'd0;
                        digit_cnt   = 4'd0;
                        parse_phase = tclp_pkg::PH_F2_START;
                    end else begin
                        parse_phase = tclp_pkg::PH_F1_MORE;
                    end
                end
            end
            tclp_pkg::PH_F2_START: begin
                acc_value = 8'd0;
                digit_cnt = 4'd0;
                if (!is_dec(c)) begin
                    expect_failure(8'd0, tclp_pkg::ST_BAD_START2);
                end else begin
                    add_digit(c);
                    if (digit_cnt >= FIELD_DIGITS)
                        complete_field_command();
                    else
                        parse_phase = tclp_pkg::PH_F2_MORE;
                end
            end
            tclp_pkg::PH_F2_MORE: begin
                if (c == tclp_pkg::CH_NUL || c == tclp_pkg::CH_COMMA) begin
                    complete_field_command();
                end else if (!is_dec(c)) begin
                    expect_failure(8'd0, tclp_pkg::ST_BAD_CHAR2);
                end else begin
                    add_digit(c);
                    if (digit_cnt >= FIELD_DIGITS)
                        complete_field_command();
                end
            end
            tclp_pkg::PH_HEX_HIGH: begin
                if (!is_hex(c)) begin
                    expect_failure({3'd0, area_group}, tclp_pkg::ST_BAD_START);
                end else begin
                    high_nibble = nibble_of(c);
                    parse_phase = tclp_pkg::PH_HEX_LOW;
                end
            end
            tclp_pkg::PH_HEX_LOW: begin
                if (!is_hex(c)) begin
                    expect_failure({3'd0, area_group}, tclp_pkg::ST_BAD_CHAR);
                end else begin
                    area_byte = {high_nibble, nibble_of(c)};
                    if (int'(area_group) + 1 >= AREA_LEN) begin
                        // last byte carries the ok status too
                        expect_write(tclp_pkg::WK_AREA, {3'd0, area_group}, area_byte, 1'b1,
                                     tclp_pkg::ST_OK);
                        parse_phase = tclp_pkg::PH_DONE;
                    end else begin
                        expect_write(tclp_pkg::WK_AREA, {3'd0, area_group}, area_byte, 1'b0,
                                     tclp_pkg::ST_OK);
                        area_group  = area_group + 5'd1;
                        parse_phase = tclp_pkg::PH_HEX_SEP;
                    end
                end
            end
            tclp_pkg::PH_HEX_SEP: begin
                if (c == tclp_pkg::CH_NUL)
                    expect_failure({3'd0, area_group}, tclp_pkg::ST_BAD_START);
                else
                    parse_phase = tclp_pkg::PH_HEX_HIGH;
            end
            default: begin
            end
        endcase
        // end of line returns the parser to its reset state
        if (c == tclp_pkg::CH_NUL)
            clear_parser_state();
    endfunction

    task automatic report_mismatch(string msg);
        error_count++;
        $display("%0t ns: %s", $time, msg);
    endtask

    // result checker
    always @(posedge i_clk) begin : check_results
        t_write got_w;
        t_write want_w;
        if (i_rst_n && o_valid && i_ready) begin
            got_w = {o_write_kind, o_target_index, o_write_value, o_status_valid, o_status};
            if (expected_writes.size() == 0) begin
                report_mismatch($sformatf("unexpected result: kind %0d target %0d value %0d",
                                          got_w.kind, got_w.target, got_w.value));
            end else begin
                want_w = expected_writes.pop_front();
                if (got_w.kind !== want_w.kind)
                    report_mismatch($sformatf("result %0d: write_kind %0d, expected %0d",
                                              results_seen, got_w.kind, want_w.kind));
                if (got_w.target !== want_w.target)
                    report_mismatch($sformatf("result %0d: target_index %0d, expected %0d",
                                              results_seen, got_w.target, want_w.target));
                if (got_w.value !== want_w.value)
                    report_mismatch($sformatf("result %0d: write_value %0d, expected %0d",
                                              results_seen, got_w.value, want_w.value));
                if (got_w.sv !== want_w.sv)
                    report_mismatch($sformatf("result %0d: status_valid %0d, expected %0d",
                                              results_seen, got_w.sv, want_w.sv));
                if (got_w.st !== want_w.st)
                    report_mismatch($sformatf("result %0d: status %0d, expected %0d",
                                              results_seen, got_w.st, want_w.st));
            end
            results_seen++;
            if (got_w.kind == tclp_pkg::WK_AREA)
                area_seen++;
            if (got_w.sv)
                status_seen++;
        end
    end

    // receiver: random stall bursts and the long hold, counted here
    initial begin : receiver
        int stall_left;
        stall_left = 0;
        forever begin
            @(posedge i_clk);
            if (hold_request) begin
                hold_request = 1'b0;
                stall_left   = HOLD_CYCLES;
            end else if (stall_left == 0 && rx_idling && $urandom_range(0, 9) == 0) begin
                stall_left = $urandom_range(1, 16);
            end
            if (stall_left > 0) begin
                i_ready <= 1'b0;
                stall_left--;
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    // one character request, predicted when accepted
    task automatic send_char(logic [7:0] c);
        int gap;
        if (tx_idling && $urandom_range(0, 9) == 0) begin
            gap = $urandom_range(1, 16);
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_ch    <= c;
        do @(posedge i_clk); while (!o_ready);
        parse_char(c);
        chars_sent++;
    endtask

    task automatic send_line();
        foreach (line_buf[k])
            send_char(line_buf[k]);
        send_char(tclp_pkg::CH_NUL);
        line_buf.delete();
    endtask

    function automatic void add_text(string s);
        for (int k = 0; k < s.len(); k++)
            line_buf.push_back(s[k]);
    endfunction

    task automatic send_text(string s);
        add_text(s);
        send_line();
    endtask

    function automatic void add_padded(int value, int width);
        int scale;
        scale = 1;
        repeat (width - 1) scale *= 10;
        repeat (width) begin
            line_buf.push_back(tclp_pkg::CH_0 + 8'((value / scale) % 10));
            scale /= 10;
        end
    endfunction

    // decimal field, mostly in range, sometimes long, large or zero padded
    function automatic void add_number(int lim);
        int pick;
        pick = $urandom_range(0, 9);
        if (pick < 6)
            add_text($sformatf("%0d", $urandom_range(0, lim)));
        else if (pick == 6)
            add_text($sformatf("%0d", lim + 1));
        else if (pick == 7)
            add_padded($urandom_range(0, lim), FIELD_DIGITS);
        else if (pick == 8)
            add_text($sformatf("%0d", $urandom_range(0, 99999)));
        else
            repeat ($urandom_range(1, FIELD_DIGITS))
                line_buf.push_back(tclp_pkg::CH_0 + 8'($urandom_range(0, 9)));
    endfunction

    function automatic logic [7:0] hex_digit(int v);
        return (v < 10) ? tclp_pkg::CH_0 + 8'(v) : tclp_pkg::CH_A + 8'(v - 10);
    endfunction

    // area byte pairs with random separators of any nonzero value
    function automatic void add_area_body();
        for (int k = 0; k < AREA_LEN; k++) begin
            if (k > 0)
                line_buf.push_back(8'($urandom_range(1, 255)));
            line_buf.push_back(hex_digit($urandom_range(0, 15)));
            line_buf.push_back(hex_digit($urandom_range(0, 15)));
        end
    endfunction

    function automatic void add_random_command();
        int pick;
        pick = $urandom_range(0, 19);
        if (pick < 2) begin
            add_text("$K");
        end else if (pick < 8) begin
            add_text("$S,");
            add_number(lim_index);
            add_text(",");
            add_number(lim_signal);
        end else if (pick < 13) begin
            add_text("$I,");
            add_number(lim_index);
            add_text(",");
            add_number(1);
        end else if (pick < 17) begin
            add_text("$A,");
            add_area_body();
        end else begin
            repeat ($urandom_range(1, 8))
                line_buf.push_back(8'($urandom_range(1, 255)));
        end
    endfunction

    // broken lines: cut short, one character replaced, or trailing junk
    function automatic void mangle_line();
        int pick;
        int n;
        pick = $urandom_range(0, 9);
        if (pick == 0 && line_buf.size() > 1) begin
            n = $urandom_range(1, line_buf.size() - 1);
            while (line_buf.size() > n)
                void'(line_buf.pop_back());
        end else if (pick == 1) begin
            line_buf[$urandom_range(0, line_buf.size() - 1)] = 8'($urandom_range(1, 255));
        end else if (pick == 2) begin
            repeat ($urandom_range(1, 4))
                line_buf.push_back(8'($urandom_range(1, 255)));
        end
    endfunction

    // both limit registers, only while nothing is in flight
    task automatic set_limits(logic [7:0] idx_lim, logic [7:0] sig_lim);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= tclp_pkg::REG_MAX_INDEX;
        i_cfg_data  <= idx_lim;
        do @(posedge i_clk); while (!o_cfg_ready);
        lim_index = idx_lim;
        i_cfg_index <= tclp_pkg::REG_MAX_SIGNAL;
        i_cfg_data  <= sig_lim;
        do @(posedge i_clk); while (!o_cfg_ready);
        lim_signal = sig_lim;
        i_cfg_valid <= 1'b0;
        settings_count++;
    endtask

    task automatic wait_idle();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (expected_writes.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    function automatic logic [7:0] pick_limit();
        int pick;
        pick = $urandom_range(0, 3);
        if (pick == 0)
            return 8'd0;
        else if (pick == 1)
            return 8'd255;
        else
            return 8'($urandom_range(0, 255));
    endfunction

    // every command, every status and the end of line cases
    task automatic test_directed_commands();
        int k;
        int value;
        tx_idling = 1'b1;
        rx_idling = 1'b1;
        send_text("$K");
        send_line();
        send_text("X$K");
        send_text("$");
        send_text("$Q");
        send_text("$S.");
        send_text("$S,");
        send_text("$S,5,2");
        send_text("$I,7,0");
        send_text("$I,7,9,1");
        send_text("$S,a");
        send_text("$S,1x");
        send_text("$S,12");
        send_text("$S,1,");
        send_text("$I,1,2y");
        send_text("$S,100,1");
        send_text("$S,99,4");
        // long fields: the tenth digit closes the field
        send_text("$S,00000000993");
        send_text("$S,0000000099,3");
        send_text("$I,9999999999999");
        send_text("$I,1,00000000001");
        send_text("$I,3,300");
        send_text("$S,99,0000000003");
        // area: full command, bad digits, end of line inside
        add_text("$A,");
        for (k = 0; k < AREA_LEN; k++) begin
            if (k > 0)
                line_buf.push_back(8'(k * 15));
            value = (k == 0) ? 0 : (k == AREA_LEN - 1) ? 255 : k * 13;
            line_buf.push_back(hex_digit(value / 16));
            line_buf.push_back(hex_digit(value % 16));
        end
        send_line();
        send_text("$A,0G");
        send_text("$A,12-x");
        send_text("$A,12");
        send_text("$A,1");
        send_text("$A,ab");
        send_text("$A,");
        send_text("$Kzz");
    endtask

    // limit extremes, with commands right at and just past them
    task automatic test_register_extremes();
        logic [7:0] idx_set [5] = '{8'd0, 8'd255, 8'd0, 8'd255, 8'd1};
        logic [7:0] sig_set [5] = '{8'd0, 8'd255, 8'd255, 8'd0, 8'd1};
        for (int k = 0; k < 5; k++) begin
            wait_idle();
            set_limits(idx_set[k], sig_set[k]);
            send_text($sformatf("$S,%0d,%0d", lim_index, lim_signal));
            send_text($sformatf("$S,%0d,%0d", lim_index + 1, lim_signal));
            send_text($sformatf("$S,%0d,%0d", lim_index, lim_signal + 1));
            send_text($sformatf("$I,%0d,1", lim_index));
            send_text("$I,0,0");
            send_text("$S,999,0");
        end
    endtask

    // mostly well-formed commands with random content, some broken, some noise
    task automatic test_random_traffic(int char_target, bit with_idling);
        int start;
        start = chars_sent;
        while (chars_sent - start < char_target) begin
            wait_idle();
            if ($urandom_range(0, 2) == 0)
                set_limits(pick_limit(), pick_limit());
            tx_idling = with_idling && ($urandom_range(0, 3) != 0);
            rx_idling = with_idling && ($urandom_range(0, 3) != 0);
            repeat (12) begin
                add_random_command();
                if ($urandom_range(0, 4) == 0)
                    mangle_line();
                send_line();
            end
        end
    endtask

    // receiver holds off while area requests keep coming
    task automatic test_receiver_hold();
        wait_idle();
        tx_idling    = 1'b0;
        rx_idling    = 1'b0;
        hold_request = 1'b1;
        repeat (4) begin
            add_text("$A,");
            add_area_body();
            send_line();
        end
        send_text("$S,1,1");
        wait_idle();
    endtask

    // sender stops mid line until every pending result is out
    task automatic test_sender_pause();
        int cut;
        wait_idle();
        tx_idling = 1'b1;
        rx_idling = 1'b1;
        repeat (6) begin
            add_text("$A,");
            add_area_body();
            cut = $urandom_range(4, line_buf.size() - 1);
            for (int k = 0; k < line_buf.size(); k++) begin
                if (k == cut) begin
                    i_valid <= 1'b0;
                    do @(posedge i_clk); while (expected_writes.size() != 0);
                end
                send_char(line_buf[k]);
            end
            send_char(tclp_pkg::CH_NUL);
            line_buf.delete();
        end
    endtask

    initial begin : run_tests
        int k;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed_commands();
        test_register_extremes();
        test_random_traffic(300, 1'b1);
        test_receiver_hold();
        test_sender_pause();
        test_random_traffic(150, 1'b0);
        // drain with a bound, then look for stray results
        i_valid <= 1'b0;
        for (k = 0; k < END_WAIT && expected_writes.size() != 0; k++)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (expected_writes.size() != 0)
            report_mismatch($sformatf("%0d expected results never arrived",
                                      expected_writes.size()));
        $display("covered %0d characters and %0d results under %0d limit settings",
                 chars_sent, results_seen, settings_count);
        $display("results held %0d area byte writes and %0d command statuses",
                 area_seen, status_seen);
        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    // run limit
    initial begin : watchdog
        #(TIMEOUT_NS);
        $display("DONE: errors detected");
        $finish;
    end

endmodule
